@@ sv/nbss_pkg.sv @@
// Shared types and constants for the nearest boundary snap search block.
// Used by the channel interfaces, the chain cell and the top level.
`timescale 1ns / 1ps
`default_nettype none

package nbss_pkg;

   // Field widths of the request and response words
   localparam int CMD_W  = 2;
   localparam int POS_W  = 32;
   localparam int STAT_W = 2;
   localparam int IDX_W  = 6;

   typedef logic [CMD_W-1:0]        cmd_type;
   typedef logic signed [POS_W-1:0] pos_type;
   typedef logic [STAT_W-1:0]       stat_type;
   typedef logic [IDX_W-1:0]        idx_type;

   // Command codes
   localparam cmd_type CMD_CLEAR  = 2'd0;
   localparam cmd_type CMD_APPEND = 2'd1;
   localparam cmd_type CMD_QUERY  = 2'd2;

   // Response status codes
   localparam stat_type STAT_OK      = 2'd0;
   localparam stat_type STAT_FOUND   = 2'd1;
   localparam stat_type STAT_NOMATCH = 2'd2;
   localparam stat_type STAT_FULL    = 2'd3;

   // Search token handed from cell to cell
   typedef struct packed {
      logic    active;
      logic    done;
      logic    found;
      idx_type idx;
      pos_type pos;
      pos_type prev;
   } tok_type;

endpackage

`default_nettype wire

@@ sv/nbss_req_if.sv @@
// Request channel of the snap search block: command and position word.
// Depends on nbss_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface nbss_req_if;
   import nbss_pkg::*;

   logic    valid;
   logic    ready;
   cmd_type cmd;
   pos_type value;

   modport source (output valid, output cmd, output value, input ready);
   modport sink   (input valid, input cmd, input value, output ready);
endinterface

`default_nettype wire

@@ sv/nbss_rsp_if.sv @@
// Response channel of the snap search block: status and boundary index.
// Depends on nbss_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface nbss_rsp_if;
   import nbss_pkg::*;

   logic     valid;
   logic     ready;
   stat_type status;
   idx_type  limit_index;

   modport source (output valid, output status, output limit_index, input ready);
   modport sink   (input valid, input status, input limit_index, output ready);
endinterface

`default_nettype wire

@@ sv/nbss_cell.sv @@
// One cell of the boundary chain: holds one boundary and, past the first cell, tests one interval.
// Depends on nbss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nbss_cell #(
   parameter int CELL_INDEX = 0,
   parameter int CW         = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [CW-1:0]    count,
   input  nbss_pkg::pos_type wr_value,
   input  nbss_pkg::tok_type up_tok,
   output nbss_pkg::tok_type dn_tok
);
   import nbss_pkg::*;

   localparam logic [CW-1:0] SELF = CW'(CELL_INDEX);

   pos_type bound_ff;
   tok_type hand_ff;
   tok_type hand_in;

   // Store the boundary when the append lands on this slot
   always_ff @(posedge clock) begin
      if (wr_en && (count == SELF)) begin
         bound_ff <= wr_value;
      end
   end

   // Pass the token on, one cell per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         hand_ff <= '0;
      end else begin
         hand_ff <= hand_in;
      end
   end

   assign dn_tok = hand_ff;

   if (CELL_INDEX == 0) begin : g_head
      // First cell only supplies the left limit to its neighbour
      always_comb begin
         hand_in      = up_tok;
         hand_in.prev = bound_ff;
      end
   end else begin : g_body
      localparam logic [CW-1:0] LEFT = CW'(CELL_INDEX - 1);

      logic signed [POS_W:0]   p_w;
      logic signed [POS_W:0]   lo_w;
      logic signed [POS_W:0]   hi_w;
      logic signed [POS_W:0]   d_lo;
      logic signed [POS_W:0]   d_hi;
      logic signed [POS_W:0]   span;
      logic signed [POS_W:0]   snap;
      logic signed [POS_W+1:0] p_x;
      logic signed [POS_W+1:0] floor_x;
      logic                    live;
      logic                    below;
      logic [CW-1:0]           pick;
      logic [CW-1:0]           last;

      // Test the interval [prev, own boundary) against the position
      always_comb begin
         p_w     = {up_tok.pos[POS_W-1], up_tok.pos};
         lo_w    = {up_tok.prev[POS_W-1], up_tok.prev};
         hi_w    = {bound_ff[POS_W-1], bound_ff};
         d_lo    = p_w - lo_w;
         d_hi    = hi_w - p_w;
         span    = hi_w - lo_w;
         snap    = span >>> 1;
         p_x     = {p_w[POS_W], p_w};
         floor_x = {lo_w[POS_W], lo_w} - {snap[POS_W], snap};
         below   = (p_w < lo_w);
         live    = up_tok.active && !up_tok.done && (SELF < count);
         last    = count - CW'(1);
         pick    = (d_lo < d_hi) ? LEFT : SELF;

         hand_in      = up_tok;
         hand_in.prev = bound_ff;
         if (live) begin
            if ((CELL_INDEX == 1) && below) begin
               // below the first boundary: snap to it within half the first width
               hand_in.done  = 1'b1;
               hand_in.found = (p_x >= floor_x);
               hand_in.idx   = '0;
            end else if (!below && (p_w < hi_w)) begin
               // nearer limit, ties to the right; the last boundary never answers
               hand_in.done  = 1'b1;
               hand_in.found = (pick != last);
               hand_in.idx   = (pick != last) ? IDX_W'(pick) : '0;
            end
         end
      end
   end

endmodule

`default_nettype wire

@@ sv/nearest_boundary_snap_search.sv @@
// A query sends a search token down the chain, which walks it one cell a cycle; clear and
// append update the table directly. Either way the result then passes the hold state into
// the output register, and no new word is taken until the last one is through.
// A waiting response sits in the output register while the next word is taken.
// Reset (synchronous, active high) empties the table and drops any search in flight;
// stored boundaries are left as they are.
`timescale 1ns / 1ps
`default_nettype none

module nearest_boundary_snap_search #(
   parameter int MAX_BOUNDARIES = 64
) (
   input logic         clock,
   input logic         reset,
   nbss_req_if.sink    req_ch,
   nbss_rsp_if.source  rsp_ch
);
   import nbss_pkg::*;

   localparam int CW = $clog2(MAX_BOUNDARIES + 1);
   localparam logic [CW-1:0] CAP = CW'(MAX_BOUNDARIES);

   typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_HOLD} state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   stat_type      res_status_ff, res_status_in;
   idx_type       res_idx_ff, res_idx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   stat_type      rsp_status_ff, rsp_status_in;
   idx_type       rsp_idx_ff, rsp_idx_in;

   logic    accept;
   logic    wr_en;
   tok_type chain [MAX_BOUNDARIES+1];
   tok_type tail;

   assign accept = req_ch.valid && req_ch.ready;
   assign wr_en  = accept && (req_ch.cmd == CMD_APPEND) && (count_ff < CAP);

   // Launch a search token into the head of the chain
   always_comb begin
      chain[0]        = '0;
      chain[0].active = accept && (req_ch.cmd == CMD_QUERY);
      chain[0].pos    = req_ch.value;
   end

   for (genvar k = 0; k < MAX_BOUNDARIES; k++) begin : g_chain
      nbss_cell #(
         .CELL_INDEX (k),
         .CW         (CW)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .wr_en    (wr_en),
         .count    (count_ff),
         .wr_value (req_ch.value),
         .up_tok   (chain[k]),
         .dn_tok   (chain[k+1])
      );
   end

   assign tail = chain[MAX_BOUNDARIES];

   // Sequence the word through table update or search, then the output register
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_idx_in    = res_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_idx_in    = rsp_idx_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_idx_in = '0;
               state_in   = S_HOLD;
               unique case (req_ch.cmd)
                  CMD_CLEAR: begin
                     count_in      = '0;
                     res_status_in = STAT_OK;
                  end
                  CMD_APPEND: begin
                     if (count_ff < CAP) begin
                        count_in      = count_ff + CW'(1);
                        res_status_in = STAT_OK;
                     end else begin
                        res_status_in = STAT_FULL;
                     end
                  end
                  CMD_QUERY: begin
                     state_in = S_SEARCH;
                  end
                  default: begin
                     res_status_in = STAT_NOMATCH;
                  end
               endcase
            end
         end
         S_SEARCH: begin
            if (tail.active) begin
               res_status_in = tail.found ? STAT_FOUND : STAT_NOMATCH;
               res_idx_in    = tail.found ? tail.idx : '0;
               state_in      = S_HOLD;
            end
         end
         S_HOLD: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_idx_in    = res_idx_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state, table fill and the response register
   always_ff @(posedge clock) begin
      res_status_ff <= res_status_in;
      res_idx_ff    <= res_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_idx_ff    <= rsp_idx_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ch.ready       = (state_ff == S_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.limit_index = rsp_idx_ff;

`ifndef ASSERT_OFF
   a_count_cap : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP)
      else $error("boundary count beyond table size");

   a_tail_in_search : assert property (@(posedge clock) disable iff (reset)
      tail.active |-> (state_ff == S_SEARCH))
      else $error("search token left the chain outside a search");

   a_append_grows : assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("append did not advance the boundary count");

   a_rsp_from_hold : assert property (@(posedge clock) disable iff (reset)
      (!$past(rsp_valid_ff) && rsp_valid_ff) |-> ($past(state_ff) == S_HOLD))
      else $error("response raised without a finished word");
`endif

endmodule

`default_nettype wire

@@ verif/nbss_snap_checker.sv @@
// Response checker for the nearest boundary snap search block: it keeps its own copy of
// the boundary table, predicts the answer to each request word and compares each response.
// Depends on nbss_pkg, nbss_req_if and nbss_rsp_if.
`timescale 1ns / 1ps

module nbss_snap_checker #(
   parameter int NB = 64
) (
   input  logic  clock,
   input  logic  reset,
   nbss_req_if   req_mon,
   nbss_rsp_if   rsp_mon,
   output int    fail_count,
   output int    pending,
   output int    checked_total,
   output int    found_total,
   output int    nomatch_total,
   output int    full_total
);
   import nbss_pkg::*;

   typedef struct packed {
      stat_type st;
      idx_type  ix;
   } answer_type;

   // Shadow of the boundary table
   pos_type    bnd_table [NB];
   int         bnd_count;
   answer_type expected_answers [$];

   int fails;
   int checked, found, nomatch, full;

   task automatic report_mismatch(input string msg);
      $display("%0t ns: %s", $time, msg);
      fails++;
   endtask

   // Find the closest usable limit for a position; 0 when there is none
   function automatic bit nearest_limit(input pos_type pos, output int unsigned hit);
      longint p, lo, hi, snap;
      hit = 0;
      p   = pos;
      if (bnd_count < 2) return 1'b0;
      // below the first boundary: snap to it within half the first width
      if (p < longint'(bnd_table[0])) begin
         lo   = bnd_table[0];
         snap = (longint'(bnd_table[1]) - lo) >>> 1;
         return p >= lo - snap;
      end
      // first interval that holds the position wins, ties go right
      for (int i = 0; i + 1 < bnd_count; i++) begin
         lo = bnd_table[i];
         hi = bnd_table[i + 1];
         if (lo <= p && p < hi) begin
            hit = (p - lo < hi - p) ? i : i + 1;
            return hit != bnd_count - 1;
         end
      end
      return 1'b0;
   endfunction

   // Apply one request word to the shadow table and give its answer
   function automatic answer_type snap_predict(input cmd_type c, input pos_type v);
      answer_type a;
      int unsigned hit;
      a.st = STAT_NOMATCH;
      a.ix = '0;
      case (c)
         CMD_CLEAR: begin
            bnd_count = 0;
            a.st      = STAT_OK;
         end
         CMD_APPEND: begin
            if (bnd_count < NB) begin
               bnd_table[bnd_count] = v;
               bnd_count++;
               a.st = STAT_OK;
            end else begin
               a.st = STAT_FULL;
            end
         end
         CMD_QUERY: begin
            if (nearest_limit(v, hit)) begin
               a.st = STAT_FOUND;
               a.ix = idx_type'(hit);
            end
         end
         default: begin
         end
      endcase
      return a;
   endfunction

   // Compare responses first, then take the request word of the same edge
   always @(posedge clock) begin : watch
      answer_type want;
      if (reset) begin
         bnd_count = 0;
         expected_answers.delete();
      end else begin
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (expected_answers.size() == 0) begin
               report_mismatch($sformatf("response with none expected: status %0d index %0d",
                                         rsp_mon.status, rsp_mon.limit_index));
            end else begin
               want = expected_answers.pop_front();
               if (rsp_mon.status !== want.st)
                  report_mismatch($sformatf("status mismatch: got %0d, expected %0d",
                                            rsp_mon.status, want.st));
               if (rsp_mon.limit_index !== want.ix)
                  report_mismatch($sformatf("limit_index mismatch: got %0d, expected %0d",
                                            rsp_mon.limit_index, want.ix));
               checked++;
               if (want.st == STAT_FOUND) found++;
               if (want.st == STAT_NOMATCH) nomatch++;
               if (want.st == STAT_FULL) full++;
            end
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            want = snap_predict(req_mon.cmd, req_mon.value);
            expected_answers.insert(expected_answers.size(), want);
         end
      end
      fail_count    <= fails;
      pending       <= expected_answers.size();
      checked_total <= checked;
      found_total   <= found;
      nomatch_total <= nomatch;
      full_total    <= full;
   end

endmodule

@@ verif/tb_nearest_boundary_snap_search.sv @@
// Testbench top for the nearest boundary snap search block: drives request words, paces
// the response side and gives the verdict. Depends on nbss_pkg, the channel interfaces,
// the block itself and nbss_snap_checker.
`timescale 1ns / 1ps

module tb_nearest_boundary_snap_search;
   import nbss_pkg::*;

   localparam int      NB          = 64;
   localparam int      ITEMS       = 1950;
   localparam int      HOLD_FROM   = 12000;
   localparam int      HOLD_LEN    = 600;
   localparam int      CALM_FROM   = 30000;
   localparam int      CALM_TO     = 45000;
   localparam int      DRAIN_LIMIT = 20000;
   localparam cmd_type CMD_UNUSED  = 2'd3;
   localparam pos_type POS_MIN     = 32'h8000_0000;
   localparam pos_type POS_MAX     = 32'h7fff_ffff;
   localparam pos_type ONE         = 32'h0001_0000;

   logic clock;
   logic reset;
   int   fail_count, pending, checked_total, found_total, nomatch_total, full_total;
   int   items_sent;

   // Boundaries the block should hold, used only to aim queries
   pos_type placed [$];

   nbss_req_if req_ch ();
   nbss_rsp_if rsp_ch ();

   nearest_boundary_snap_search #(
      .MAX_BOUNDARIES(NB)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   nbss_snap_checker #(
      .NB(NB)
   ) i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .fail_count    (fail_count),
      .pending       (pending),
      .checked_total (checked_total),
      .found_total   (found_total),
      .nomatch_total (nomatch_total),
      .full_total    (full_total)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard limit on the whole run
   initial begin
      #16_000_000;
      $display("run limit reached with %0d responses outstanding", pending);
      $display("FAIL nearest_boundary_snap_search");
      $finish;
   end

   // Response side: random stalls, one long hold-off, one calm stretch
   initial begin : rsp_pacing
      int cycles;
      cycles = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles >= HOLD_FROM && cycles < HOLD_FROM + HOLD_LEN)
            rsp_ch.ready <= 1'b0;
         else if (cycles >= CALM_FROM && cycles < CALM_TO)
            rsp_ch.ready <= 1'b1;
         else
            rsp_ch.ready <= ($urandom_range(0, 99) >= 23);
      end
   end

   // Offer one word, idling at random first; valid stays high on return
   task automatic send_word(input cmd_type c, input pos_type v);
      while (!(items_sent >= 600 && items_sent < 900) && $urandom_range(0, 99) < 23) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.cmd   <= c;
      req_ch.value <= v;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      items_sent++;
      case (c)
         CMD_CLEAR: begin
            placed.delete();
         end
         CMD_APPEND: begin
            if (placed.size() < NB) placed.insert(placed.size(), v);
         end
         default: begin
         end
      endcase
   endtask

   // Append n boundaries, ascending with a random stride, or in any order
   task automatic load_table(input int n, input bit ordered);
      longint      acc;
      int unsigned stride;
      case ($urandom_range(0, 2))
         0: begin
            stride = 8;
            acc    = longint'(pos_type'($urandom())) >>> 1;
         end
         1: begin
            stride = 32'h0010_0000;
            acc    = -longint'($urandom_range(0, 32'h4000_0000));
         end
         default: begin
            stride = 32'h0400_0000;
            acc    = longint'(POS_MIN) + $urandom_range(0, 32'h0010_0000);
         end
      endcase
      repeat (n) begin
         if (ordered) begin
            send_word(CMD_APPEND, pos_type'(acc));
            acc += $urandom_range(0, stride);
            if (acc > longint'(POS_MAX)) acc = POS_MAX;
         end else begin
            send_word(CMD_APPEND, pos_type'($urandom()));
         end
      end
   endtask

   // Pick a query at boundaries, midpoints, the snap edge or noise, or another command
   task automatic choose_probe(output cmd_type c, output pos_type v);
      int unsigned r, i;
      int          m;
      longint      a, b;
      m = placed.size();
      r = $urandom_range(0, 99);
      c = CMD_QUERY;
      v = pos_type'($urandom());
      if (r < 30 && m > 0) begin
         i = $urandom_range(0, m - 1);
         v = pos_type'(longint'(placed[i]) + int'($urandom_range(0, 4)) - 2);
      end else if (r < 50 && m > 1) begin
         i = $urandom_range(0, m - 2);
         a = placed[i];
         b = placed[i + 1];
         v = pos_type'(((a + b) >>> 1) + int'($urandom_range(0, 2)) - 1);
      end else if (r < 65 && m > 1) begin
         a = placed[0];
         b = placed[1];
         v = pos_type'(a - ((b - a) >>> 1) + int'($urandom_range(0, 2)) - 1);
      end else if (r < 75 && m > 0) begin
         v = pos_type'(longint'(placed[m - 1]) + int'($urandom_range(0, 2)) - 1);
      end else if (r < 80) begin
         v = $urandom_range(0, 1) ? POS_MIN : POS_MAX;
      end else if (r < 86) begin
         c = CMD_UNUSED;
      end else if (r < 90) begin
         c = CMD_APPEND;
      end else if (r < 92) begin
         c = CMD_CLEAR;
      end
   endtask

   initial begin : stimulus
      cmd_type     c;
      pos_type     v;
      int          n, q, waited;
      int unsigned r;
      bit          paused;
      paused     = 1'b0;
      items_sent = 0;
      req_ch.valid <= 1'b0;
      req_ch.cmd   <= CMD_CLEAR;
      req_ch.value <= '0;
      reset        <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty and single-entry tables never match; the unused command changes nothing
      send_word(CMD_QUERY, ONE);
      send_word(CMD_UNUSED, ONE);
      send_word(CMD_APPEND, ONE);
      send_word(CMD_QUERY, ONE);
      send_word(CMD_APPEND, 3 * ONE);
      send_word(CMD_APPEND, 5 * ONE);
      // Snap edge below the first boundary, tie going right, last boundary and beyond
      send_word(CMD_QUERY, '0);
      send_word(CMD_QUERY, pos_type'(-1));
      send_word(CMD_QUERY, ONE);
      send_word(CMD_QUERY, 2 * ONE);
      send_word(CMD_QUERY, 2 * ONE - 1);
      send_word(CMD_QUERY, 4 * ONE);
      send_word(CMD_QUERY, 5 * ONE);
      send_word(CMD_UNUSED, pos_type'(-1));
      // Full-range interval
      send_word(CMD_CLEAR, POS_MAX);
      send_word(CMD_APPEND, POS_MIN);
      send_word(CMD_APPEND, POS_MAX);
      send_word(CMD_QUERY, POS_MIN);
      send_word(CMD_QUERY, POS_MAX);
      send_word(CMD_QUERY, pos_type'(-1));
      send_word(CMD_QUERY, '0);
      // Descending table gives a negative snap range
      send_word(CMD_CLEAR, POS_MIN);
      send_word(CMD_APPEND, 32'sd3);
      send_word(CMD_APPEND, 32'sd0);
      send_word(CMD_QUERY, 32'sd2);

      // Random sets: clear, fill, then probe
      while (items_sent < ITEMS) begin
         if (!paused && items_sent >= 1000) begin
            // hold the input until every outstanding response is back
            paused = 1'b1;
            req_ch.valid <= 1'b0;
            do @(posedge clock); while (pending != 0);
         end
         send_word(CMD_CLEAR, pos_type'($urandom()));
         r = $urandom_range(0, 99);
         if (r < 6)       n = $urandom_range(0, 1);
         else if (r < 14) n = NB + $urandom_range(1, 3);
         else if (r < 28) n = $urandom_range(13, 40);
         else             n = $urandom_range(2, 12);
         load_table(n, $urandom_range(0, 9) != 0);
         q = (n >= NB) ? $urandom_range(12, 24) : $urandom_range(3, 14);
         repeat (q) begin
            choose_probe(c, v);
            send_word(c, v);
         end
      end
      req_ch.valid <= 1'b0;

      // Drain, then allow one full search time for anything stray
      waited = 0;
      do begin
         @(posedge clock);
         waited++;
      end while (pending != 0 && waited < DRAIN_LIMIT);
      if (pending != 0) begin
         $display("timed out with %0d responses outstanding", pending);
         $display("FAIL nearest_boundary_snap_search");
         $finish;
      end else begin
         repeat (NB + 20) @(posedge clock);
         $display("sent %0d words; checked %0d responses: %0d found, %0d no match, %0d full",
                  items_sent, checked_total, found_total, nomatch_total, full_total);
         $display("tables up to %0d entries, %0d-cycle response hold-off, one drained pause",
                  NB, HOLD_LEN);
         if (fail_count == 0 && pending == 0) begin
            $display("PASS nearest_boundary_snap_search");
         end else begin
            $display("%0d mismatches, %0d responses outstanding", fail_count, pending);
            $display("FAIL nearest_boundary_snap_search");
         end
         $finish;
      end
   end

endmodule

@@ files.f @@
sv/nbss_pkg.sv
sv/nbss_req_if.sv
sv/nbss_rsp_if.sv
sv/nbss_cell.sv
sv/nearest_boundary_snap_search.sv
verif/nbss_snap_checker.sv
verif/tb_nearest_boundary_snap_search.sv
